/* sv/lmr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Loopback message rings package
// Request kinds and field widths shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package lmr_pkg;

    localparam int KIND_W   = 2;
    localparam int OFFSET_W = 11;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 12;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_TAKE   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] msg_length;
    } take_t;

endpackage
`default_nettype wire

/* sv/lmr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Loopback message rings channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface lmr_req_if
    import lmr_pkg::*;
    ();
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic                side;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   data_in;
    logic [LEN_W-1:0]    length;

    modport source (output valid, kind, side, offset, data_in, length, input ready);
    modport sink   (input valid, kind, side, offset, data_in, length, output ready);
endinterface

interface lmr_rsp_if
    import lmr_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [LEN_W-1:0]  msg_length;
    logic [BYTE_W-1:0] data_out;

    modport source (output valid, found, msg_length, data_out, input ready);
    modport sink   (input valid, found, msg_length, data_out, output ready);
endinterface
`default_nettype wire

/* sv/lmr_byte_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message byte store
// Synchronous byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lmr_byte_store
    import lmr_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* sv/lmr_ring_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ring pointer control
// Write, occupancy and taken pointers of both rings and the slot length memory.
// ----------------------------------------------------------------------------
module lmr_ring_ctrl
    import lmr_pkg::*;
#(
    parameter int MSG_BYTES  = 2048,
    parameter int RING_SLOTS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire kind_t                         kind,
    input  wire logic                          side,
    input  wire logic [LEN_W-1:0]              length,
    output logic      [$clog2(RING_SLOTS)-1:0] send_slot,
    output logic      [$clog2(RING_SLOTS)-1:0] taken_slot,
    output take_t                              take
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int OCC_W  = $clog2(RING_SLOTS + 1);
    localparam int SUM_W  = OCC_W + 1;

    logic [SLOT_W-1:0] write_slot_reg [2];
    logic [SLOT_W-1:0] write_slot_next [2];
    logic [OCC_W-1:0]  occupancy_reg [2];
    logic [OCC_W-1:0]  occupancy_next [2];
    logic [SLOT_W-1:0] taken_slot_reg [2];
    logic [SLOT_W-1:0] taken_slot_next [2];
    logic              found_reg;
    logic              found_next;

    logic [LEN_W-1:0]  len_mem [2 * (2 ** SLOT_W)];
    logic [LEN_W-1:0]  len_rd_reg;

    logic              dest;
    logic [SLOT_W-1:0] dest_slot;
    logic [OCC_W-1:0]  side_occ;
    logic [SUM_W-1:0]  wrap_sum;
    logic [SLOT_W-1:0] oldest_slot;
    logic [LEN_W-1:0]  sat_len;
    logic              len_wr;
    logic              len_rd;

    assign dest      = ~side;
    assign dest_slot = write_slot_reg[dest];
    assign side_occ  = occupancy_reg[side];
    assign send_slot = dest_slot;
    assign taken_slot = taken_slot_reg[side];

    always_comb
    begin
        if (SUM_W'(write_slot_reg[side]) >= SUM_W'(side_occ))
        begin
            wrap_sum = SUM_W'(write_slot_reg[side]) - SUM_W'(side_occ);
        end
        else
        begin
            wrap_sum = SUM_W'(write_slot_reg[side]) + SUM_W'(RING_SLOTS) - SUM_W'(side_occ);
        end
        oldest_slot = wrap_sum[SLOT_W-1:0];
    end

    always_comb
    begin
        if (32'(length) > 32'(MSG_BYTES))
        begin
            sat_len = LEN_W'(MSG_BYTES);
        end
        else
        begin
            sat_len = length;
        end
    end

    assign len_wr = accept && (kind == KIND_COMMIT);
    assign len_rd = accept && (kind == KIND_TAKE);

    always_comb
    begin
        write_slot_next = write_slot_reg;
        occupancy_next  = occupancy_reg;
        taken_slot_next = taken_slot_reg;
        found_next      = found_reg;
        if (accept)
        begin
            found_next = 1'b0;
            unique case (kind)
                KIND_COMMIT:
                begin
                    if (32'(dest_slot) == RING_SLOTS - 1)
                    begin
                        write_slot_next[dest] = '0;
                    end
                    else
                    begin
                        write_slot_next[dest] = dest_slot + SLOT_W'(1);
                    end
                    if (32'(occupancy_reg[dest]) < RING_SLOTS)
                    begin
                        occupancy_next[dest] = occupancy_reg[dest] + OCC_W'(1);
                    end
                end
                KIND_TAKE:
                begin
                    if (side_occ != '0)
                    begin
                        occupancy_next[side]  = side_occ - OCC_W'(1);
                        taken_slot_next[side] = oldest_slot;
                        found_next            = 1'b1;
                    end
                end
                KIND_WRITE, KIND_READ:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '{default: '0};
            occupancy_reg  <= '{default: '0};
            taken_slot_reg <= '{default: '0};
            found_reg      <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            occupancy_reg  <= occupancy_next;
            taken_slot_reg <= taken_slot_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_wr)
        begin
            len_mem[{dest, dest_slot}] <= sat_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_rd)
        begin
            len_rd_reg <= len_mem[{side, oldest_slot}];
        end
    end

    assign take.found      = found_reg;
    assign take.msg_length = found_reg ? len_rd_reg : '0;

endmodule
`default_nettype wire

/* sv/loopback_message_rings.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Loopback message rings
// Two overwrite-oldest message rings, one per direction, for a local socket.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the req channel: kind 0 writes a byte of the
// message being sent, kind 1 commits its length and advances the ring of the
// opposite side, kind 2 takes the oldest message of the requesting side and
// kind 3 reads a byte of the message last taken by that side. Every request
// beat produces exactly one response beat on the rsp channel, in order.
// The response of a request accepted at a clock edge is valid after that
// edge. The block accepts one request beat per cycle while the response is
// not stalled; the single read port of the byte memory and of the length
// memory sets that figure, each request touching at most one word of each.
// The response stage is one register; while the receiver stalls it holds the
// beat and req.ready stays low, and a new request is taken in the same cycle
// that the waiting response beat is taken.
// Reset clears the ring pointers and the response stage; message bytes and
// lengths are undefined until written, and need no clearing pass.
// ----------------------------------------------------------------------------
module loopback_message_rings
    import lmr_pkg::*;
#(
    parameter int MSG_BYTES  = 2048,
    parameter int RING_SLOTS = 4
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lmr_req_if.sink   req,
    lmr_rsp_if.source rsp
);

    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int BYTE_DEPTH = 2 * RING_SLOTS * MSG_BYTES;
    localparam int ADDR_W     = $clog2(BYTE_DEPTH);

    logic              accept;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              rd_hit_reg;
    logic              rd_hit_next;
    logic              off_ok;
    logic [SLOT_W-1:0] send_slot;
    logic [SLOT_W-1:0] taken_slot;
    take_t             take;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              byte_wr;
    logic              byte_rd;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign off_ok    = 32'(req.offset) < MSG_BYTES;

    assign wr_addr = (ADDR_W'(!req.side) * ADDR_W'(RING_SLOTS) + ADDR_W'(send_slot))
                     * ADDR_W'(MSG_BYTES) + ADDR_W'(req.offset);
    assign rd_addr = (ADDR_W'(req.side) * ADDR_W'(RING_SLOTS) + ADDR_W'(taken_slot))
                     * ADDR_W'(MSG_BYTES) + ADDR_W'(req.offset);

    assign byte_wr = accept && (req.kind == KIND_WRITE) && off_ok;
    assign byte_rd = accept && (req.kind == KIND_READ) && off_ok;

    lmr_ring_ctrl #(
        .MSG_BYTES  (MSG_BYTES),
        .RING_SLOTS (RING_SLOTS)
    ) u_ring_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (req.kind),
        .side       (req.side),
        .length     (req.length),
        .send_slot  (send_slot),
        .taken_slot (taken_slot),
        .take       (take)
    );

    lmr_byte_store #(
        .DEPTH  (BYTE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (byte_wr),
        .wr_addr (wr_addr),
        .wr_data (req.data_in),
        .rd_en   (byte_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rd_hit_next    = rd_hit_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rd_hit_next    = byte_rd;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rd_hit_reg    <= rd_hit_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = take.found;
    assign rsp.msg_length = take.msg_length;
    assign rsp.data_out   = rd_hit_reg ? rd_data : '0;

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.data_out == '0)
        else $error("Taken message beat carries a data byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.msg_length == '0)
        else $error("Length reported without a taken message.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 32'(rsp.msg_length) <= MSG_BYTES)
        else $error("Reported length exceeds the slot size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data_out)
                                    && $stable(rsp.msg_length))
        else $error("Stalled response beat changed.");

endmodule
`default_nettype wire
